/* rtl/ippf_pkg.sv */
// Package for the IPv6 prefix and port filter: sizes, codes, chain word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ippf_pkg;

   localparam int MAX_FILTERS = 16;
   localparam int IDX_W       = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int CNT_W       = $clog2(MAX_FILTERS + 1);
   localparam int ADDR_W      = 128;
   localparam int PORT_W      = 16;
   localparam int LEN_W       = 8;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_ZERO_LEN = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic [LEN_W-1:0] LEN_FULL     = 8'd128;
   localparam logic [LEN_W-1:0] LEN_V4_MAX   = 8'd32;
   localparam logic [LEN_W-1:0] LEN_V4_SHIFT = 8'd96;
   localparam logic [63:0]      V4_MAPPED    = 64'h0000_ffff_0000_0000;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [PORT_W-1:0] port;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
   } scan_type;

   // keep the top len bits; len is already saturated to 128
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len >= LEN_FULL) begin
         m = {ADDR_W{1'b1}};
      end else begin
         m = ~({ADDR_W{1'b1}} >> len);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/ippf_cell.sv */
// One filter cell of the scan chain: holds one entry, tests the passing query word.
// Depends on ippf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ippf_cell
   import ippf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic             in_use,
   input  wire logic             wr_en,
   input  wire entry_type        wr_entry,
   input  wire scan_type         scan_in,
   output scan_type              scan_out
);

   entry_type entry_ff;
   scan_type  scan_ff;
   scan_type  scan_in_w;
   logic      hit;

   always_comb begin
      hit = in_use
         && ((entry_ff.port == '0) || (entry_ff.port == scan_in.port))
         && ((scan_in.addr & entry_ff.mask) == entry_ff.prefix);
      scan_in_w = scan_in;
      if (scan_in.valid && !scan_in.found && hit) begin
         scan_in_w.found = 1'b1;
         scan_in_w.idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff.valid <= scan_in_w.valid;
      end
      scan_ff.found <= scan_in_w.found;
      scan_ff.idx   <= scan_in_w.idx;
      scan_ff.addr  <= scan_in_w.addr;
      scan_ff.port  <= scan_in_w.port;
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire

/* rtl/ipv6_prefix_port_filter_core.sv */
// Top level of the IPv6 prefix and port filter: command decode, table fill and scan chain.
// Depends on ippf_pkg and ippf_cell.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken when start is high and busy is low; its result appears on the
// rsp_ ports for one cycle with rsp_valid high and must be captured then, since
// there is no way to hold it off. Clear and add words answer in the cycle after
// acceptance and busy stays low, so words may come back to back. A query walks
// the chain of MAX_FILTERS cells, one cell per cycle, and is answered from the
// response register once it leaves the last cell; busy is high until the cycle
// before the answer. The first matching cell in table order wins.
module ipv6_prefix_port_filter_core
   import ippf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_op,
   input  wire logic [63:0]       req_addr_hi,
   input  wire logic [63:0]       req_addr_lo,
   input  wire logic              req_is_ipv4,
   input  wire logic [LEN_W-1:0]  req_prefix_len,
   input  wire logic [PORT_W-1:0] req_port,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_bypass,
   output logic [3:0]             rsp_match_index
);

   logic              accept;
   logic              scan_ff, scan_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_bypass_ff, rsp_bypass_in;
   logic [3:0]        rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0] addr;
   logic [LEN_W-1:0]  len;
   logic              add_ok;
   entry_type         new_entry;
   scan_type          chain [MAX_FILTERS+1];

   assign accept = start && !scan_ff;
   assign busy   = scan_ff;

   always_comb begin
      if (req_is_ipv4) begin
         addr = {64'd0, V4_MAPPED | {32'd0, req_addr_lo[31:0]}};
      end else begin
         addr = {req_addr_hi, req_addr_lo};
      end
      len = req_prefix_len;
      if (req_is_ipv4 && (len <= LEN_V4_MAX)) begin
         len = len + LEN_V4_SHIFT;
      end
      if (len > LEN_FULL) begin
         len = LEN_FULL;
      end
      new_entry.mask   = prefix_mask(len);
      new_entry.prefix = addr & new_entry.mask;
      new_entry.port   = req_port;
      add_ok = accept && (req_op == OP_ADD) && (req_prefix_len != '0)
         && (count_ff < CNT_W'(MAX_FILTERS));
   end

   assign chain[0] = {accept && (req_op == OP_QUERY), 1'b0, {IDX_W{1'b0}}, addr, req_port};

   for (genvar i = 0; i < MAX_FILTERS; i++) begin : g_cell
      ippf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .in_use   (CNT_W'(i) < count_ff),
         .wr_en    (add_ok && (count_ff == CNT_W'(i))),
         .wr_entry (new_entry),
         .scan_in  (chain[i]),
         .scan_out (chain[i+1])
      );
   end

   always_comb begin
      scan_in       = scan_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_bypass_in = 1'b0;
      rsp_index_in  = '0;
      if (scan_ff) begin
         if (chain[MAX_FILTERS].valid) begin
            scan_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_bypass_in = chain[MAX_FILTERS].found;
            if (chain[MAX_FILTERS].found) begin
               rsp_index_in = 4'(chain[MAX_FILTERS].idx);
            end
         end
      end else if (accept) begin
         unique case (req_op)
            OP_CLEAR: begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
            end
            OP_ADD: begin
               rsp_valid_in = 1'b1;
               if (req_prefix_len == '0) begin
                  rsp_status_in = ST_ZERO_LEN;
               end else if (!add_ok) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_QUERY: begin
               scan_in = 1'b1;
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_bypass_ff <= rsp_bypass_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bypass      = rsp_bypass_ff;
   assign rsp_match_index = rsp_index_ff;

endmodule

`default_nettype wire

/* dv/ipv6_prefix_port_filter_core_test.sv */
// Testbench for ipv6_prefix_port_filter_core: directed and random clear, add and query words,
// checked against an in-bench filter table predictor. Depends on ippf_pkg and the core RTL.
`timescale 1ns / 1ps

module ipv6_prefix_port_filter_core_test;
   import ippf_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         CYCLE_CAP  = 600000;
   localparam int         DRAIN_WAIT = 40;

   typedef struct {
      logic [1:0]        op;
      logic [63:0]       addr_hi;
      logic [63:0]       addr_lo;
      logic              is_ipv4;
      logic [LEN_W-1:0]  prefix_len;
      logic [PORT_W-1:0] port;
   } filter_word_type;

   typedef struct {
      logic [1:0] status;
      logic       bypass;
      logic [3:0] index;
   } verdict_type;

   // added address kept for building hitting queries
   typedef struct {
      logic [127:0]      addr;
      logic              is_ipv4;
      int                eff_len;
      logic [PORT_W-1:0] port;
   } known_prefix_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_op;
   logic [63:0]       req_addr_hi;
   logic [63:0]       req_addr_lo;
   logic              req_is_ipv4;
   logic [LEN_W-1:0]  req_prefix_len;
   logic [PORT_W-1:0] req_port;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic              rsp_bypass;
   logic [3:0]        rsp_match_index;

   // predicted filter table
   logic [127:0]      tbl_prefix [MAX_FILTERS];
   int                tbl_len    [MAX_FILTERS];
   logic [PORT_W-1:0] tbl_port   [MAX_FILTERS];
   int                tbl_count;

   verdict_type      verdict_q [$];
   known_prefix_type known_q   [$];
   int               mismatch_count;
   int               word_count;
   int               idle_pct;
   int               cycle_count;

   ipv6_prefix_port_filter_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_addr_hi     (req_addr_hi),
      .req_addr_lo     (req_addr_lo),
      .req_is_ipv4     (req_is_ipv4),
      .req_prefix_len  (req_prefix_len),
      .req_port        (req_port),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_bypass      (rsp_bypass),
      .rsp_match_index (rsp_match_index)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [127:0] keep_mask(input int len);
      logic [127:0] m;
      if (len <= 0) begin
         m = '0;
      end else begin
         m = {128{1'b1}} << (128 - len);
      end
      return m;
   endfunction

   function automatic logic [127:0] word_address(input filter_word_type w);
      logic [127:0] a;
      if (w.is_ipv4) begin
         a = {64'd0, V4_MAPPED | {32'd0, w.addr_lo[31:0]}};
      end else begin
         a = {w.addr_hi, w.addr_lo};
      end
      return a;
   endfunction

   // updates the predicted table and returns the verdict for one word
   function automatic verdict_type filter_verdict(input filter_word_type w);
      verdict_type  v;
      int           len;
      logic [127:0] a;
      logic         found;
      v.status = ST_DONE;
      v.bypass = 1'b0;
      v.index  = 4'd0;
      case (w.op)
         OP_CLEAR: begin
            tbl_count = 0;
         end
         OP_ADD: begin
            len = int'(w.prefix_len);
            if (len == 0) begin
               v.status = ST_ZERO_LEN;
            end else if (tbl_count >= MAX_FILTERS) begin
               v.status = ST_FULL;
            end else begin
               if (w.is_ipv4 && len <= 32) len = len + 96;
               if (len > 128) len = 128;
               tbl_prefix[tbl_count] = word_address(w) & keep_mask(len);
               tbl_len[tbl_count]    = len;
               tbl_port[tbl_count]   = w.port;
               tbl_count++;
            end
         end
         OP_QUERY: begin
            a     = word_address(w);
            found = 1'b0;
            for (int i = 0; i < tbl_count; i++) begin
               if (!found && (tbl_port[i] == '0 || tbl_port[i] == w.port) &&
                   (a & keep_mask(tbl_len[i])) == tbl_prefix[i]) begin
                  found    = 1'b1;
                  v.bypass = 1'b1;
                  v.index  = i[3:0];
               end
            end
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d bypass %0d index %0d",
                        rsp_status, rsp_bypass, rsp_match_index);
         end else begin
            exp_v = verdict_q.pop_front();
            if (rsp_status !== exp_v.status || rsp_bypass !== exp_v.bypass ||
                rsp_match_index !== exp_v.index) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d bypass %0d index %0d, got %0d %0d %0d",
                           exp_v.status, exp_v.bypass, exp_v.index,
                           rsp_status, rsp_bypass, rsp_match_index);
            end
         end
      end
   end

   function automatic filter_word_type make_word(input logic [1:0] op, input logic [63:0] hi,
                                                 input logic [63:0] lo, input logic v4,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [PORT_W-1:0] port);
      filter_word_type w;
      w.op         = op;
      w.addr_hi    = hi;
      w.addr_lo    = lo;
      w.is_ipv4    = v4;
      w.prefix_len = len;
      w.port       = port;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_word(input filter_word_type w);
      logic accepted;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_op         = w.op;
      req_addr_hi    = w.addr_hi;
      req_addr_lo    = w.addr_lo;
      req_is_ipv4    = w.is_ipv4;
      req_prefix_len = w.prefix_len;
      req_port       = w.port;
      start          = 1'b1;
      accepted       = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         if (!busy) accepted = 1'b1;
         else @(negedge clock);
      end
      verdict_q.push_back(filter_verdict(w));
      word_count++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_word(make_word(OP_QUERY, '1, '1, 1'b0, 8'd0, 16'hffff));
      send_word(make_word(OP_QUERY, '0, '0, 1'b1, 8'hff, 16'd0));
      send_word(make_word(OP_UNUSED, '1, '1, 1'b1, 8'hff, 16'hffff));
   endtask

   task automatic test_add_rejects();
      send_word(make_word(OP_ADD, '1, '1, 1'b0, 8'd0, 16'd0));
      send_word(make_word(OP_ADD, '0, 64'h0a01_0203, 1'b1, 8'd0, 16'd80));
      send_word(make_word(OP_QUERY, '1, '1, 1'b0, 8'd0, 16'd0));
   endtask

   task automatic test_prefix_lengths();
      send_word(make_word(OP_CLEAR, '0, '0, 1'b0, 8'd0, 16'd0));
      send_word(make_word(OP_ADD, '1, '1, 1'b0, 8'hff, 16'd0));
      send_word(make_word(OP_ADD, '1, 64'hdead_beef_0a01_0203, 1'b1, 8'd24, 16'd80));
      send_word(make_word(OP_ADD, 64'h8000_0000_0000_0001, 64'h1, 1'b0, 8'd1, 16'd443));
      send_word(make_word(OP_ADD, '0, 64'hc0a8_0001, 1'b1, 8'd64, 16'd0));
      send_word(make_word(OP_QUERY, '1, '1, 1'b0, 8'd7, 16'd9));
      send_word(make_word(OP_QUERY, '0, 64'h0a01_0263, 1'b1, 8'd0, 16'd80));
      send_word(make_word(OP_QUERY, '0, V4_MAPPED | 64'h0a01_0263, 1'b0, 8'd0, 16'd80));
      send_word(make_word(OP_QUERY, 64'hf000_0000_0000_0000, '0, 1'b0, 8'd0, 16'd443));
      send_word(make_word(OP_QUERY, 64'hf000_0000_0000_0000, '0, 1'b0, 8'd0, 16'd444));
      send_word(make_word(OP_QUERY, '0, 64'h0a01_0263, 1'b1, 8'd0, 16'd81));
      send_word(make_word(OP_QUERY, 64'h7fff_ffff_ffff_ffff, '1, 1'b0, 8'd0, 16'hffff));
   endtask

   task automatic test_clear();
      send_word(make_word(OP_CLEAR, '1, '1, 1'b1, 8'hff, 16'hffff));
      send_word(make_word(OP_QUERY, '1, '1, 1'b0, 8'd0, 16'd0));
   endtask

   function automatic logic [PORT_W-1:0] pick_port();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: return 16'd0;
         4: return 16'd80;
         5: return 16'd443;
         6: return 16'd8080;
         7: return 16'hffff;
         default: return PORT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_add();
      filter_word_type  w;
      known_prefix_type k;
      int               r;
      int               len;
      w.op      = OP_ADD;
      w.addr_hi = rand64();
      w.addr_lo = rand64();
      w.is_ipv4 = ($urandom_range(0, 9) < 3);
      w.port    = pick_port();
      r         = $urandom_range(0, 99);
      if (r < 4) len = 0;
      else if (r < 9) len = $urandom_range(129, 255);
      else if (r < 14) len = 128;
      else if (w.is_ipv4 && r < 80) len = $urandom_range(1, 32);
      else len = $urandom_range(1, 128);
      w.prefix_len = LEN_W'(len);
      send_word(w);
      if (len != 0) begin
         if (w.is_ipv4 && len <= 32) len = len + 96;
         if (len > 128) len = 128;
         k.addr    = {w.addr_hi, w.addr_lo};
         k.is_ipv4 = w.is_ipv4;
         k.eff_len = len;
         k.port    = w.port;
         known_q.push_back(k);
      end
   endtask

   task automatic send_query();
      filter_word_type  w;
      known_prefix_type k;
      logic [127:0]     a;
      int               bits;
      int               r;
      w.op         = OP_QUERY;
      w.prefix_len = LEN_W'($urandom_range(0, 255));
      if (known_q.size() == 0 || $urandom_range(0, 9) == 0) begin
         w.addr_hi = rand64();
         w.addr_lo = rand64();
         w.is_ipv4 = 1'($urandom_range(0, 1));
         w.port    = pick_port();
      end else begin
         k = known_q[$urandom_range(0, known_q.size() - 1)];
         if ($urandom_range(0, 3) != 0) bits = $urandom_range(0, 128 - k.eff_len);
         else bits = $urandom_range(0, 128);
         a = k.addr ^ ({rand64(), rand64()} & ~({128{1'b1}} << bits));
         w.addr_hi = a[127:64];
         w.addr_lo = a[63:0];
         w.is_ipv4 = k.is_ipv4;
         if (k.is_ipv4 && $urandom_range(0, 4) == 0) begin
            w.is_ipv4 = 1'b0;
            w.addr_hi = '0;
            w.addr_lo = V4_MAPPED | {32'd0, a[31:0]};
         end
         r = $urandom_range(0, 9);
         if (r < 6 && k.port != '0) w.port = k.port;
         else if (r < 8) w.port = PORT_W'($urandom_range(0, 65535));
         else w.port = pick_port();
      end
      send_word(w);
   endtask

   task automatic send_noise();
      send_word(make_word(2'($urandom_range(0, 3)), rand64(), rand64(),
                          1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 255)),
                          PORT_W'($urandom_range(0, 65535))));
   endtask

   // usually clear, fill the table, then query mostly around stored prefixes
   task automatic filter_session();
      int n_add;
      int n_query;
      if ($urandom_range(0, 9) < 8) begin
         send_word(make_word(OP_CLEAR, rand64(), rand64(), 1'($urandom_range(0, 1)),
                             LEN_W'($urandom_range(0, 255)),
                             PORT_W'($urandom_range(0, 65535))));
         known_q.delete();
      end
      n_add   = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
      n_query = $urandom_range(4, 14);
      repeat (n_add) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_add();
      end
      repeat (n_query) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_query();
      end
   endtask

   task automatic test_random_traffic(input int pct, input int n_words);
      int target;
      int half;
      idle_pct = pct;
      target   = word_count + n_words;
      half     = word_count + n_words / 2;
      while (word_count < half) filter_session();
      hold_until_drained();
      while (word_count < target) filter_session();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_CLEAR;
      req_addr_hi    = '0;
      req_addr_lo    = '0;
      req_is_ipv4    = 1'b0;
      req_prefix_len = '0;
      req_port       = '0;
      tbl_count      = 0;
      mismatch_count = 0;
      word_count     = 0;
      cycle_count    = 0;
      idle_pct       = 19;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_add_rejects();
      test_prefix_lengths();
      test_clear();
      test_random_traffic(19, 510);
      test_random_traffic(58, 510);
      test_random_traffic(0, 510);

      hold_until_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && verdict_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* ipv6_prefix_port_filter_core.f */
rtl/ippf_pkg.sv
rtl/ippf_cell.sv
rtl/ipv6_prefix_port_filter_core.sv
dv/ipv6_prefix_port_filter_core_test.sv
